// ----- hw/rtl/ntc_beta_temperature_converter_unit_assert.svh -----
// assertion macros for the ntc beta temperature converter
`ifndef NTC_BETA_TEMPERATURE_CONVERTER_UNIT_ASSERT_SVH
`define NTC_BETA_TEMPERATURE_CONVERTER_UNIT_ASSERT_SVH
// same-cycle implication
`define NTCB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ntcb assertion failed");
// next-cycle implication
`define NTCB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ntcb assertion failed");
`endif

// ----- hw/rtl/ntcb_pkg.sv -----
// package: types and constants of the ntc beta temperature converter
package ntcb_pkg;

  localparam int NUM_CHANNELS_DEF = 3;
  localparam int ADC_BITS_DEF     = 12;

  localparam logic [19:0] RAIL_K     = 20'd999999;
  localparam logic [63:0] LN2_Q30    = 64'd744261118;
  localparam logic [63:0] LN_RND     = 64'd1 << 33;
  localparam logic [12:0] TEMP_OFS   = 13'd5463;
  localparam logic [6:0]  LOG_STEPS  = 7'd28;
  localparam logic [6:0]  DIV_STEPS  = 7'd64;
  localparam logic [5:0]  NORM_TOP   = 6'd39;

  localparam logic        RST_TO_GROUND  = 1'b1;
  localparam logic [15:0] RST_FULL_SCALE = 16'd4095;
  localparam logic [19:0] RST_SERIES_R   = 20'd10000;
  localparam logic [19:0] RST_NOMINAL_R  = 20'd10000;
  localparam logic [13:0] RST_BETA       = 14'd3950;
  localparam logic [15:0] RST_NOMINAL_T  = 16'd29815;
  localparam logic [15:0] RST_MIN_T      = 16'hFE70;
  localparam logic [15:0] RST_MAX_T      = 16'd1250;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_N,
    S_MUL_D,
    S_NORM,
    S_LOG,
    S_MUL_LN,
    S_MUL_TK,
    S_MUL_TB,
    S_MUL_DEN,
    S_DIV,
    S_FIN
  } state_t;

  typedef enum logic [2:0] {
    CFG_TO_GROUND,
    CFG_FULL_SCALE,
    CFG_SERIES_R,
    CFG_NOMINAL_R,
    CFG_BETA,
    CFG_NOMINAL_T,
    CFG_MIN_T,
    CFG_MAX_T
  } cfg_idx_t;

endpackage

// ----- hw/rtl/ntc_beta_temperature_converter_unit.sv -----
// top level: ntc thermistor beta-equation temperature converter
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready   | in_channel, in_adc_raw
//  out     | output    | out_valid / out_ready | out_channel, out_converted_dc, out_in_range,
//          |           |                       | out_held_temp_dc, out_held_valid
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one transaction at a time, built from the shift-add multiplier (one multiplier bit a cycle),
// two leading-one scans, two 28-step log2 squaring loops and a 64-step restoring divider;
// the divide is skipped when 1/T is not positive.
// the next input is taken as soon as the result sits in the output register.
// rst_n is synchronous; reset loads the register defaults and clears all stored temps.
// a stalled output only holds the final state; cfg writes are always taken.
module ntc_beta_temperature_converter_unit #(
  parameter int NUM_CHANNELS = ntcb_pkg::NUM_CHANNELS_DEF,
  parameter int ADC_BITS     = ntcb_pkg::ADC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_channel,
  input  logic [ADC_BITS-1:0] in_adc_raw,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_channel,
  output logic signed [15:0]  out_converted_dc,
  output logic                out_in_range,
  output logic signed [15:0]  out_held_temp_dc,
  output logic                out_held_valid,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [19:0]         cfg_data
);

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [4:0] NUM_CH_V = 5'(NUM_CHANNELS);

  // configuration registers
  logic               cfg_to_ground_r;
  logic [15:0]        cfg_full_scale_r;
  logic [19:0]        cfg_series_r_r;
  logic [19:0]        cfg_nominal_r_r;
  logic [13:0]        cfg_beta_r;
  logic [15:0]        cfg_nominal_t_r;
  logic signed [15:0] cfg_min_t_r;
  logic signed [15:0] cfg_max_t_r;

  logic [15:0] full_scale;
  logic [19:0] series_r;
  logic [19:0] nominal_r;
  logic [13:0] beta;
  logic [15:0] nominal_t;

  ntcb_pkg::state_t state_r, state_nxt;

  // datapath registers
  logic [1:0]  chan_r;
  logic [19:0] y_d_r;
  logic [63:0] mc_r;
  logic [33:0] mp_r;
  logic [63:0] acc_r;
  logic [39:0] n_r;
  logic [39:0] d_r;
  logic [39:0] w_r;
  logic [5:0]  k_r;
  logic [31:0] m_r;
  logic [27:0] frac_r;
  logic [6:0]  cnt_r;
  logic        second_r;
  logic [33:0] ln_n_r;
  logic        neg_r;
  logic signed [47:0] den_r;
  logic [29:0] tkb_r;
  logic        above_r;
  logic [63:0] dvd_r;
  logic [48:0] rem_r;
  logic [48:0] dvs_r;
  logic        div_neg_r;

  logic [1:0]         out_channel_r;
  logic signed [15:0] out_conv_r;
  logic               out_range_r;
  logic signed [15:0] out_held_r;
  logic               out_hvalid_r;
  logic               out_valid_r;

  logic signed [15:0] temp_store_r [NUM_CHANNELS];
  logic               valid_mark_r [NUM_CHANNELS];

  // combinational signals
  logic [15:0] a16;
  logic [19:0] a20, fma20, y_n, y_d;
  logic        rail_lo, rail_hi;
  logic        mul_done;
  logic [63:0] acc_step;
  logic [63:0] sq;
  logic [32:0] sq_sh;
  logic [31:0] m_step;
  logic [27:0] frac_step;
  logic [33:0] log_val;
  logic        ln_neg;
  logic [33:0] mag;
  logic [63:0] acc_rnd;
  logic [20:0] b100;
  logic signed [47:0] lqtk;
  logic signed [47:0] den_calc;
  logic        den_pos;
  logic [34:0] tkb20;
  logic signed [63:0] numer;
  logic [63:0] numer_mag;
  logic [49:0] rem_sh;
  logic        rem_ge;
  logic [48:0] rem_nxt;
  logic signed [63:0] val;
  logic        below, over, ok;
  logic signed [15:0] res;
  logic        chan_ok;
  logic [CH_W-1:0] idx;
  logic        fin_fire;
  logic        cnt_last;

  // zero full-scale, resistance, beta and nominal-temperature registers act as one
  assign full_scale = (cfg_full_scale_r == '0) ? 16'd1 : cfg_full_scale_r;
  assign series_r   = (cfg_series_r_r == '0) ? 20'd1 : cfg_series_r_r;
  assign nominal_r  = (cfg_nominal_r_r == '0) ? 20'd1 : cfg_nominal_r_r;
  assign beta       = (cfg_beta_r == '0) ? 14'd1 : cfg_beta_r;
  assign nominal_t  = (cfg_nominal_t_r == '0) ? 16'd1 : cfg_nominal_t_r;

  assign cfg_ready = 1'b1;

  // divider ratio factors, rails clamp the ratio to 1:999999 or 999999:1
  always_comb begin
    a16     = 16'(in_adc_raw);
    a20     = 20'(a16);
    fma20   = 20'(full_scale) - a20;
    rail_lo = (a16 == '0);
    rail_hi = (a16 >= full_scale);
    priority if (rail_lo) begin
      y_n = cfg_to_ground_r ? 20'd1 : ntcb_pkg::RAIL_K;
      y_d = cfg_to_ground_r ? ntcb_pkg::RAIL_K : 20'd1;
    end else if (rail_hi) begin
      y_n = cfg_to_ground_r ? ntcb_pkg::RAIL_K : 20'd1;
      y_d = cfg_to_ground_r ? 20'd1 : ntcb_pkg::RAIL_K;
    end else if (cfg_to_ground_r) begin
      y_n = a20;
      y_d = fma20;
    end else begin
      y_n = fma20;
      y_d = a20;
    end
  end

  // shift-add multiplier, log2 squaring step, divider step
  always_comb begin
    mul_done  = (mp_r == '0);
    acc_step  = mp_r[0] ? acc_r + mc_r : acc_r;
    sq        = m_r * m_r;
    sq_sh     = sq[63:31];
    m_step    = sq_sh[32] ? sq_sh[32:1] : sq_sh[31:0];
    frac_step = {frac_r[26:0], sq_sh[32]};
    log_val   = {k_r, frac_step};
    ln_neg    = (log_val > ln_n_r);
    mag       = ln_neg ? (log_val - ln_n_r) : (ln_n_r - log_val);
    acc_rnd   = acc_r + ntcb_pkg::LN_RND;
    b100      = (21'(beta) << 6) + (21'(beta) << 5) + (21'(beta) << 2);
    lqtk      = neg_r ? -$signed({2'b00, acc_r[45:0]}) : $signed({2'b00, acc_r[45:0]});
    den_calc  = $signed({3'b000, b100, 24'd0}) + lqtk;
    den_pos   = !den_r[47] && (den_r != '0);
    tkb20     = (35'(tkb_r) << 4) + (35'(tkb_r) << 2);
    numer     = $signed({5'd0, tkb20, 24'd0}) - $signed(acc_r);
    numer_mag = numer[63] ? 64'(-numer) : 64'(numer);
    rem_sh    = {rem_r, dvd_r[63]};
    rem_ge    = (rem_sh >= {1'b0, dvs_r});
    rem_nxt   = rem_ge ? 49'(rem_sh - {1'b0, dvs_r}) : rem_sh[48:0];
    cnt_last  = (cnt_r == 7'd1);
  end

  // range check and channel store lookup
  always_comb begin
    val     = div_neg_r ? -$signed(dvd_r) : $signed(dvd_r);
    below   = !above_r && (val < 64'(cfg_min_t_r));
    over    = above_r || (val > 64'(cfg_max_t_r));
    ok      = !below && !over;
    if (below) begin
      res = cfg_min_t_r;
    end else if (over) begin
      res = cfg_max_t_r;
    end else begin
      res = val[15:0];
    end
    chan_ok = ({3'b000, chan_r} < NUM_CH_V);
    idx     = CH_W'(chan_r);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ntcb_pkg::S_IDLE:    if (in_valid) state_nxt = ntcb_pkg::S_MUL_N;
      ntcb_pkg::S_MUL_N:   if (mul_done) state_nxt = ntcb_pkg::S_MUL_D;
      ntcb_pkg::S_MUL_D:   if (mul_done) state_nxt = ntcb_pkg::S_NORM;
      ntcb_pkg::S_NORM:    if (w_r[39]) state_nxt = ntcb_pkg::S_LOG;
      ntcb_pkg::S_LOG: begin
        if (cnt_last) state_nxt = second_r ? ntcb_pkg::S_MUL_LN : ntcb_pkg::S_NORM;
      end
      ntcb_pkg::S_MUL_LN:  if (mul_done) state_nxt = ntcb_pkg::S_MUL_TK;
      ntcb_pkg::S_MUL_TK:  if (mul_done) state_nxt = ntcb_pkg::S_MUL_TB;
      ntcb_pkg::S_MUL_TB: begin
        if (mul_done) state_nxt = den_pos ? ntcb_pkg::S_MUL_DEN : ntcb_pkg::S_FIN;
      end
      ntcb_pkg::S_MUL_DEN: if (mul_done) state_nxt = ntcb_pkg::S_DIV;
      ntcb_pkg::S_DIV:     if (cnt_last) state_nxt = ntcb_pkg::S_FIN;
      ntcb_pkg::S_FIN:     if (!out_valid_r || out_ready) state_nxt = ntcb_pkg::S_IDLE;
      default:             state_nxt = ntcb_pkg::S_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    in_ready = (state_r == ntcb_pkg::S_IDLE);
    fin_fire = (state_r == ntcb_pkg::S_FIN) && (!out_valid_r || out_ready);
  end

  assign out_valid        = out_valid_r;
  assign out_channel      = out_channel_r;
  assign out_converted_dc = out_conv_r;
  assign out_in_range     = out_range_r;
  assign out_held_temp_dc = out_held_r;
  assign out_held_valid   = out_hvalid_r;

  // control state, configuration and channel store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ntcb_pkg::S_IDLE;
      out_valid_r      <= 1'b0;
      cfg_to_ground_r  <= ntcb_pkg::RST_TO_GROUND;
      cfg_full_scale_r <= ntcb_pkg::RST_FULL_SCALE;
      cfg_series_r_r   <= ntcb_pkg::RST_SERIES_R;
      cfg_nominal_r_r  <= ntcb_pkg::RST_NOMINAL_R;
      cfg_beta_r       <= ntcb_pkg::RST_BETA;
      cfg_nominal_t_r  <= ntcb_pkg::RST_NOMINAL_T;
      cfg_min_t_r      <= $signed(ntcb_pkg::RST_MIN_T);
      cfg_max_t_r      <= $signed(ntcb_pkg::RST_MAX_T);
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        temp_store_r[i] <= '0;
        valid_mark_r[i] <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      if (fin_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (ntcb_pkg::cfg_idx_t'(cfg_index))
          ntcb_pkg::CFG_TO_GROUND:  cfg_to_ground_r  <= cfg_data[0];
          ntcb_pkg::CFG_FULL_SCALE: cfg_full_scale_r <= cfg_data[15:0];
          ntcb_pkg::CFG_SERIES_R:   cfg_series_r_r   <= cfg_data;
          ntcb_pkg::CFG_NOMINAL_R:  cfg_nominal_r_r  <= cfg_data;
          ntcb_pkg::CFG_BETA:       cfg_beta_r       <= cfg_data[13:0];
          ntcb_pkg::CFG_NOMINAL_T:  cfg_nominal_t_r  <= cfg_data[15:0];
          ntcb_pkg::CFG_MIN_T:      cfg_min_t_r      <= $signed(cfg_data[15:0]);
          ntcb_pkg::CFG_MAX_T:      cfg_max_t_r      <= $signed(cfg_data[15:0]);
          default: ;
        endcase
      end
      if (fin_fire && chan_ok) begin
        valid_mark_r[idx] <= ok;
        if (ok) temp_store_r[idx] <= res;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ntcb_pkg::S_IDLE: begin
        if (in_valid) begin
          chan_r <= in_channel;
          y_d_r  <= y_d;
          mc_r   <= 64'(series_r);
          mp_r   <= 34'(y_n);
          acc_r  <= '0;
        end
      end
      ntcb_pkg::S_MUL_N: begin
        if (mul_done) begin
          n_r   <= acc_r[39:0];
          mc_r  <= 64'(nominal_r);
          mp_r  <= 34'(y_d_r);
          acc_r <= '0;
        end else begin
          acc_r <= acc_step;
          mc_r  <= mc_r << 1;
          mp_r  <= mp_r >> 1;
        end
      end
      ntcb_pkg::S_MUL_D: begin
        if (mul_done) begin
          d_r      <= acc_r[39:0];
          w_r      <= n_r;
          k_r      <= ntcb_pkg::NORM_TOP;
          second_r <= 1'b0;
        end else begin
          acc_r <= acc_step;
          mc_r  <= mc_r << 1;
          mp_r  <= mp_r >> 1;
        end
      end
      ntcb_pkg::S_NORM: begin
        // shift up to the leading one
        if (w_r[39]) begin
          m_r    <= w_r[39:8];
          frac_r <= '0;
          cnt_r  <= ntcb_pkg::LOG_STEPS;
        end else begin
          w_r <= w_r << 1;
          k_r <= k_r - 6'd1;
        end
      end
      ntcb_pkg::S_LOG: begin
        m_r    <= m_step;
        frac_r <= frac_step;
        cnt_r  <= cnt_r - 7'd1;
        if (cnt_last) begin
          if (!second_r) begin
            ln_n_r   <= log_val;
            w_r      <= d_r;
            k_r      <= ntcb_pkg::NORM_TOP;
            second_r <= 1'b1;
          end else begin
            neg_r <= ln_neg;
            mc_r  <= ntcb_pkg::LN2_Q30;
            mp_r  <= mag;
            acc_r <= '0;
          end
        end
      end
      ntcb_pkg::S_MUL_LN: begin
        if (mul_done) begin
          mc_r  <= 64'(acc_rnd[63:34]);
          mp_r  <= 34'(nominal_t);
          acc_r <= '0;
        end else begin
          acc_r <= acc_step;
          mc_r  <= mc_r << 1;
          mp_r  <= mp_r >> 1;
        end
      end
      ntcb_pkg::S_MUL_TK: begin
        if (mul_done) begin
          den_r <= den_calc;
          mc_r  <= 64'(nominal_t);
          mp_r  <= 34'(beta);
          acc_r <= '0;
        end else begin
          acc_r <= acc_step;
          mc_r  <= mc_r << 1;
          mp_r  <= mp_r >> 1;
        end
      end
      ntcb_pkg::S_MUL_TB: begin
        if (mul_done) begin
          // 1/T <= 0 counts as hotter than any limit
          tkb_r   <= acc_r[29:0];
          above_r <= !den_pos;
          mc_r    <= 64'(unsigned'(den_r));
          mp_r    <= 34'(ntcb_pkg::TEMP_OFS);
          acc_r   <= '0;
        end else begin
          acc_r <= acc_step;
          mc_r  <= mc_r << 1;
          mp_r  <= mp_r >> 1;
        end
      end
      ntcb_pkg::S_MUL_DEN: begin
        if (mul_done) begin
          dvd_r     <= numer_mag;
          div_neg_r <= numer[63];
          dvs_r     <= {unsigned'(den_r), 1'b0};
          rem_r     <= '0;
          cnt_r     <= ntcb_pkg::DIV_STEPS;
        end else begin
          acc_r <= acc_step;
          mc_r  <= mc_r << 1;
          mp_r  <= mp_r >> 1;
        end
      end
      ntcb_pkg::S_DIV: begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[62:0], rem_ge};
        cnt_r <= cnt_r - 7'd1;
      end
      ntcb_pkg::S_FIN: begin
        if (fin_fire) begin
          out_channel_r <= chan_r;
          out_conv_r    <= res;
          out_range_r   <= ok;
          out_held_r    <= chan_ok ? (ok ? res : temp_store_r[idx]) : 16'sd0;
          out_hvalid_r  <= chan_ok && ok;
        end
      end
      default: ;
    endcase
  end

`include "ntc_beta_temperature_converter_unit_assert.svh"

  `NTCB_ASSERT_IMP(a_busy_not_ready, state_r != ntcb_pkg::S_IDLE, !in_ready)
  `NTCB_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_r == ntcb_pkg::S_MUL_N)
  `NTCB_ASSERT_IMP(a_held_needs_range, out_valid && out_held_valid, out_in_range)
  `NTCB_ASSERT_NEXT(a_fin_delivers, fin_fire, out_valid_r && state_r == ntcb_pkg::S_IDLE)

endmodule
